FILE: rtl/core/wdwr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wdwr_pkg;

	localparam int SLOTS      = 16;
	localparam int COUNT_BITS = 8;
	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam int TYPE_W     = 2;
	localparam int INDEX_W    = 4;
	localparam int ECOUNT_W   = 8;
	localparam int TAG_W      = 16;
	localparam int PICK_W     = 17;
	localparam int TOTAL_W    = 12;
	localparam int FRAC_BITS  = 16;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [PICK_W-1:0]  ONE_Q16   = PICK_W'(1) << FRAC_BITS;

	// running sum of all slot counts never exceeds SLOTS * (2^COUNT_BITS - 1)
	localparam int ACC_W    = COUNT_BITS + SLOT_W;
	localparam int TARGET_W = PICK_W + TOTAL_W;
	localparam int CMP_W    = (TARGET_W > ACC_W + FRAC_BITS) ? TARGET_W : ACC_W + FRAC_BITS;
	localparam int SUM_W    = ((TOTAL_W > COUNT_BITS) ? TOTAL_W : COUNT_BITS) + 1;

	localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_LOAD  = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_DRAW  = 2'd2;
	localparam logic [TYPE_W-1:0] REQ_NOP   = 2'd3;

	typedef struct packed {
		logic [TYPE_W-1:0]   req_type;
		logic [INDEX_W-1:0]  entry_index;
		logic [ECOUNT_W-1:0] entry_count;
		logic [TAG_W-1:0]    entry_tag;
		logic [PICK_W-1:0]   pick_fraction;
	} req_t;

	typedef struct packed {
		logic               found;
		logic [TAG_W-1:0]   drawn_tag;
		logic [TOTAL_W-1:0] remaining_total;
	} rsp_t;

	// slot table write side
	typedef struct packed {
		logic                  clr;
		logic                  wr_en;
		logic                  tag_en;
		logic [SLOT_W-1:0]     addr;
		logic [COUNT_BITS-1:0] count;
		logic [TAG_W-1:0]      tag;
	} tbl_wr_t;

	// accumulate and compare unit control
	typedef struct packed {
		logic load;
		logic step;
	} acc_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/wdwr_table.sv
`timescale 1ns / 1ps
`default_nettype none

module wdwr_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire wdwr_pkg::tbl_wr_t              wr,
	input  wire logic [wdwr_pkg::SLOT_W-1:0]    rd_addr,
	output logic      [wdwr_pkg::COUNT_BITS-1:0] rd_count,
	output logic      [wdwr_pkg::TAG_W-1:0]     rd_tag
);
	import wdwr_pkg::*;

	logic [COUNT_BITS-1:0] counts_q [SLOTS];
	logic [TAG_W-1:0]      tags_q   [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				counts_q[i] <= '0;
			end
		end else if (wr.clr) begin
			for (int i = 0; i < SLOTS; i++) begin
				counts_q[i] <= '0;
			end
		end else if (wr.wr_en) begin
			counts_q[wr.addr] <= wr.count;
		end
	end

	// a tag is only read out of a slot whose count is nonzero, so it needs no clear
	always_ff @(posedge clk) begin
		if (wr.tag_en) begin
			tags_q[wr.addr] <= wr.tag;
		end
	end

	assign rd_count = counts_q[rd_addr];
	assign rd_tag   = tags_q[rd_addr];

endmodule

`default_nettype wire

FILE: rtl/core/wdwr_pick.sv
`timescale 1ns / 1ps
`default_nettype none

module wdwr_pick (
	input  wire logic                            clk,
	input  wire wdwr_pkg::acc_ctl_t              ctl,
	input  wire logic [wdwr_pkg::PICK_W-1:0]     pick,
	input  wire logic [wdwr_pkg::TOTAL_W-1:0]    total,
	input  wire logic [wdwr_pkg::COUNT_BITS-1:0] count,
	output logic                                 hit
);
	import wdwr_pkg::*;

	logic [TARGET_W-1:0] target_q;
	logic [ACC_W-1:0]    acc_q;
	logic [ACC_W-1:0]    acc_nxt;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			target_q <= TARGET_W'(pick) * TARGET_W'(total);
			acc_q    <= '0;
		end else if (ctl.step) begin
			acc_q <= acc_nxt;
		end
	end

	assign acc_nxt = acc_q + ACC_W'(count);

	// empty slots never qualify, even with a zero target
	assign hit = (count != '0) &&
		(CMP_W'(target_q) <= (CMP_W'(acc_nxt) << FRAC_BITS));

endmodule

`default_nettype wire

FILE: rtl/core/weighted_draw_without_replacement_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake             payload
// req      in   req_valid/req_stall   req_t: req_type entry_index entry_count entry_tag
//                                      pick_fraction
// rsp      out  rsp_valid/rsp_stall   rsp_t: found drawn_tag remaining_total
//
// clear, load and no-op requests finish in the transfer cycle; the result shows next cycle.
// a draw with a nonzero total scans the slots in order through the accumulate/compare unit
// after the transfer up to the chosen slot; a draw on a zero total ends in the transfer cycle.
// one request is in flight at a time; req_stall is high while a draw scans or while a
// result waits in the output register under rsp_stall.
// reset clears all slot counts and the total at once; no request is pending after reset.

module weighted_draw_without_replacement_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire wdwr_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output wdwr_pkg::rsp_t      rsp
);
	import wdwr_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

	logic                  state_q;
	logic [SLOT_W-1:0]     scan_q;
	logic [TOTAL_W-1:0]    total_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic                  req_xfer;
	logic                  rsp_xfer;
	tbl_wr_t               tbl_wr;
	acc_ctl_t              acc_ctl;
	logic [SLOT_W-1:0]     rd_addr;
	logic [COUNT_BITS-1:0] rd_count;
	logic [TAG_W-1:0]      rd_tag;
	logic                  hit;
	logic [PICK_W-1:0]     pick_c;
	logic                  in_range;
	logic [COUNT_BITS-1:0] load_count;
	logic [SUM_W-1:0]      base;
	logic [SUM_W-1:0]      sum;
	logic [TOTAL_W-1:0]    load_total;

	logic                  finish;
	rsp_t                  rsp_d;
	logic [TOTAL_W-1:0]    total_d;
	logic                  state_d;

	assign req_stall = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign req_xfer  = req_valid && !req_stall;
	assign rsp_xfer  = rsp_valid_q && !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign rd_addr = (state_q == ST_SCAN) ? scan_q : SLOT_W'(req.entry_index);

	assign pick_c     = (req.pick_fraction > ONE_Q16) ? ONE_Q16 : req.pick_fraction;
	assign in_range   = 32'(req.entry_index) < SLOTS;
	assign load_count = COUNT_BITS'(req.entry_count);

	// reload takes the old slot count off the total first, then saturates
	assign base = (SUM_W'(total_q) >= SUM_W'(rd_count)) ?
		SUM_W'(total_q) - SUM_W'(rd_count) : '0;
	assign sum        = base + SUM_W'(load_count);
	assign load_total = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum);

	wdwr_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (tbl_wr),
		.rd_addr  (rd_addr),
		.rd_count (rd_count),
		.rd_tag   (rd_tag)
	);

	wdwr_pick u_pick (
		.clk   (clk),
		.ctl   (acc_ctl),
		.pick  (pick_c),
		.total (total_q),
		.count (rd_count),
		.hit   (hit)
	);

	always_comb begin
		tbl_wr         = '0;
		tbl_wr.addr    = rd_addr;
		tbl_wr.count   = load_count;
		tbl_wr.tag     = req.entry_tag;
		acc_ctl        = '0;
		finish         = 1'b0;
		rsp_d          = '0;
		total_d        = total_q;
		state_d        = state_q;

		case (state_q)
			ST_IDLE: begin
				if (req_xfer) begin
					case (req.req_type)
						REQ_CLEAR: begin
							tbl_wr.clr = 1'b1;
							total_d    = '0;
							finish     = 1'b1;
						end
						REQ_LOAD: begin
							if (in_range) begin
								tbl_wr.wr_en  = 1'b1;
								tbl_wr.tag_en = 1'b1;
								total_d       = load_total;
							end
							finish = 1'b1;
						end
						REQ_DRAW: begin
							if (total_q == '0) begin
								finish = 1'b1;
							end else begin
								acc_ctl.load = 1'b1;
								state_d      = ST_SCAN;
							end
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				acc_ctl.step = 1'b1;
				if (hit) begin
					tbl_wr.wr_en    = 1'b1;
					tbl_wr.count    = rd_count - COUNT_BITS'(1);
					total_d         = total_q - TOTAL_W'(1);
					rsp_d.found     = 1'b1;
					rsp_d.drawn_tag = rd_tag;
					finish          = 1'b1;
					state_d         = ST_IDLE;
				end else if (scan_q == LAST_SLOT) begin
					// only reachable if the total exceeds the sum of the slot counts
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		rsp_d.remaining_total = total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			total_q <= total_d;
			if (state_q == ST_SCAN) begin
				scan_q <= scan_q + SLOT_W'(1);
			end else begin
				scan_q <= '0;
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_xfer) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/wdwr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module wdwr_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire wdwr_pkg::req_t req,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire wdwr_pkg::rsp_t rsp
);
	import wdwr_pkg::*;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// no new request goes in while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request taken while result is stalled");

	// a clear answers in the next cycle with an empty table
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.req_type == REQ_CLEAR |=>
			rsp_valid && !rsp.found && rsp.remaining_total == '0)
		else $error("clear did not report an empty table");

	// nothing found means a zero tag
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.drawn_tag == '0)
		else $error("tag reported without a selection");

endmodule

bind weighted_draw_without_replacement_core wdwr_checker u_wdwr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire

FILE: tb/sv/weighted_draw_without_replacement_core_tb.sv
`timescale 1ns / 1ps

module weighted_draw_without_replacement_core_tb;
	import wdwr_pkg::*;

	localparam int IDLE_PCT     = 38;
	localparam int WORK_ITEMS   = 1750;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 80;
	localparam int CALM_FROM    = 900;
	localparam int CALM_TO      = 1200;
	localparam int TAIL_CYCLES  = 2 * (SLOTS + 2);
	localparam int MAX_REPORTS  = 10;
	localparam int PICK_MAX     = (1 << PICK_W) - 1;

	typedef struct {
		req_t item;
		bit   drain;
	} queued_req_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_stall = 1'b0;
	logic req_stall;
	logic rsp_valid;
	req_t req       = '0;
	rsp_t rsp;

	queued_req_t req_queue[$];
	rsp_t        pending_rsp[$];

	// local copy of the slot table
	logic [COUNT_BITS-1:0] tbl_count [SLOTS];
	logic [TAG_W-1:0]      tbl_tag [SLOTS];
	logic [TOTAL_W-1:0]    tbl_total;

	int n_accepted  = 0;
	int n_results   = 0;
	int n_mismatch  = 0;
	int n_clear     = 0;
	int n_load      = 0;
	int n_nop       = 0;
	int n_hit       = 0;
	int n_miss      = 0;
	int n_work      = 0;
	int idle_cycles = 0;
	int hold_left   = 0;
	bit held_once   = 1'b0;
	bit offer_live  = 1'b0;

	weighted_draw_without_replacement_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	function automatic void clear_table();
		for (int s = 0; s < SLOTS; s++) begin
			tbl_count[s] = '0;
			tbl_tag[s]   = '0;
		end
		tbl_total = '0;
	endfunction

	// applies one request to the table copy and returns the result it should give
	function automatic rsp_t apply_request(req_t r);
		rsp_t             res;
		logic [63:0]      target;
		logic [63:0]      acc;
		logic [PICK_W:0]  pick;
		int               base;
		int               sum;
		bit               done;
		res  = '0;
		done = 1'b0;
		case (r.req_type)
			REQ_CLEAR: begin
				clear_table();
				n_clear++;
			end
			REQ_LOAD: begin
				n_load++;
				if (int'(r.entry_index) < SLOTS) begin
					base = int'(tbl_total) - int'(tbl_count[r.entry_index]);
					if (base < 0)
						base = 0;
					sum = base + int'(r.entry_count[COUNT_BITS-1:0]);
					tbl_total = (sum > int'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum);
					tbl_count[r.entry_index] = r.entry_count[COUNT_BITS-1:0];
					tbl_tag[r.entry_index]   = r.entry_tag;
				end
			end
			REQ_DRAW: begin
				pick = (r.pick_fraction > ONE_Q16) ? {1'b0, ONE_Q16} : {1'b0, r.pick_fraction};
				if (tbl_total != '0) begin
					target = 64'(pick) * 64'(tbl_total);
					acc    = '0;
					for (int s = 0; s < SLOTS; s++) begin
						if (!done && tbl_count[s] != '0) begin
							acc = acc + 64'(tbl_count[s]);
							if (target <= (acc << FRAC_BITS)) begin
								tbl_count[s]  = tbl_count[s] - COUNT_BITS'(1);
								tbl_total     = tbl_total - TOTAL_W'(1);
								res.found     = 1'b1;
								res.drawn_tag = tbl_tag[s];
								done          = 1'b1;
							end
						end
					end
				end
				if (done)
					n_hit++;
				else
					n_miss++;
			end
			default: n_nop++;
		endcase
		res.remaining_total = tbl_total;
		return res;
	endfunction

	function automatic void add_req(logic [TYPE_W-1:0] kind, int idx, int cnt, int tag, int pick,
			bit drain);
		queued_req_t q;
		q.item.req_type      = kind;
		q.item.entry_index   = INDEX_W'(idx);
		q.item.entry_count   = ECOUNT_W'(cnt);
		q.item.entry_tag     = TAG_W'(tag);
		q.item.pick_fraction = PICK_W'(pick);
		q.drain              = drain;
		req_queue.push_back(q);
		if (kind != REQ_NOP)
			n_work++;
	endfunction

	function automatic int rand_pick();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return 0;
		if (roll < 20)
			return int'(ONE_Q16);
		if (roll < 30)
			return $urandom_range(int'(ONE_Q16) + 1, PICK_MAX);
		return $urandom_range(0, int'(ONE_Q16));
	endfunction

	// mostly small counts so that tables run dry and empty draws happen
	function automatic int rand_count();
		int roll;
		roll = $urandom_range(99);
		if (roll < 50)
			return $urandom_range(1, 4);
		if (roll < 70)
			return 0;
		if (roll < 90)
			return $urandom_range(5, 40);
		return $urandom_range(200, 255);
	endfunction

	function automatic bit calm_now();
		return n_accepted >= CALM_FROM && n_accepted < CALM_TO;
	endfunction

	function automatic void build_stimulus();
		int  ep;
		int  roll;
		bit  drain;
		// empty table, extremes, reload, zero slot, clamp of the pick, no-op
		add_req(REQ_DRAW, 0, 0, 0, 0, 1'b0);
		add_req(REQ_DRAW, 15, 255, 16'hFFFF, PICK_MAX, 1'b0);
		add_req(REQ_LOAD, 0, 255, 16'hFFFF, 0, 1'b0);
		add_req(REQ_LOAD, 15, 1, 16'h0000, PICK_MAX, 1'b0);
		add_req(REQ_DRAW, 0, 0, 0, 0, 1'b0);
		add_req(REQ_DRAW, 0, 0, 0, int'(ONE_Q16), 1'b0);
		add_req(REQ_DRAW, 0, 0, 0, PICK_MAX, 1'b0);
		add_req(REQ_LOAD, 0, 2, 16'h1234, 0, 1'b0);
		add_req(REQ_LOAD, 9, 0, 16'hBEEF, 0, 1'b0);
		add_req(REQ_LOAD, 5, 1, 16'h8001, 0, 1'b0);
		add_req(REQ_DRAW, 0, 0, 0, 32768, 1'b0);
		add_req(REQ_DRAW, 0, 0, 0, int'(ONE_Q16), 1'b0);
		add_req(REQ_DRAW, 0, 0, 0, int'(ONE_Q16), 1'b0);
		add_req(REQ_DRAW, 0, 0, 0, 0, 1'b0);
		add_req(REQ_NOP, 15, 255, 16'hFFFF, PICK_MAX, 1'b0);
		add_req(REQ_LOAD, 15, 255, 16'hA5A5, 0, 1'b0);
		add_req(REQ_NOP, 0, 0, 0, 0, 1'b0);
		add_req(REQ_CLEAR, 15, 255, 16'hFFFF, PICK_MAX, 1'b0);
		add_req(REQ_DRAW, 0, 0, 0, int'(ONE_Q16), 1'b0);
		add_req(REQ_LOAD, 3, 255, 16'h5A5A, 0, 1'b0);
		add_req(REQ_LOAD, 12, 128, 16'h7FFF, 0, 1'b0);
		add_req(REQ_DRAW, 0, 0, 0, 1, 1'b0);
		add_req(REQ_DRAW, 0, 0, 0, int'(ONE_Q16) - 1, 1'b0);
		add_req(REQ_DRAW, 0, 0, 0, int'(ONE_Q16) + 1, 1'b0);

		n_work = 0;
		ep     = 0;
		while (n_work < WORK_ITEMS) begin
			ep++;
			drain = (ep % 40 == 20);
			if (drain || $urandom_range(5) == 0)
				add_req(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, drain);
			if ($urandom_range(99) < 15) begin
				repeat ($urandom_range(1, 5))
					add_req(TYPE_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
						$urandom, 1'b0);
			end
			repeat ($urandom_range(1, 6))
				add_req(REQ_LOAD, $urandom_range(0, 15), rand_count(), $urandom, $urandom, 1'b0);
			repeat ($urandom_range(1, 14)) begin
				roll = $urandom_range(99);
				if (roll < 8)
					add_req(REQ_LOAD, $urandom_range(0, 15), rand_count(), $urandom, $urandom,
						1'b0);
				else if (roll < 12)
					add_req(REQ_NOP, $urandom, $urandom, $urandom, $urandom, 1'b0);
				else
					add_req(REQ_DRAW, $urandom, $urandom, $urandom, rand_pick(), 1'b0);
			end
		end
	endfunction

	// request side: offer at the falling edge, keep the payload until the transfer
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!offer_live) begin
			if (req_queue.size() == 0 || (req_queue[0].drain && pending_rsp.size() != 0) ||
					(hold_left == 0 && !calm_now() && $urandom_range(99) < IDLE_PCT)) begin
				req_valid <= 1'b0;
			end else begin
				req        <= req_queue[0].item;
				req_valid  <= 1'b1;
				offer_live <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) begin
			pending_rsp.push_back(apply_request(req));
			req_queue.delete(0);
			offer_live <= 1'b0;
			n_accepted++;
		end
	end

	// result side: random stalls outside the calm window and one long hold-off so the block backs up into its input
	always @(negedge clk) begin
		if (!held_once && n_results >= HOLD_AT) begin
			held_once <= 1'b1;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= !calm_now() && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			n_results++;
			if (pending_rsp.size() == 0) begin
				if (n_mismatch < MAX_REPORTS)
					$display("result %0d unexpected: found=%0b tag=%h total=%0d",
						n_results, rsp.found, rsp.drawn_tag, rsp.remaining_total);
				n_mismatch++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.found !== want.found || rsp.drawn_tag !== want.drawn_tag ||
						rsp.remaining_total !== want.remaining_total) begin
					if (n_mismatch < MAX_REPORTS) begin
						$display("result %0d differs: want found=%0b tag=%h total=%0d",
							n_results, want.found, want.drawn_tag, want.remaining_total);
						$display("  got found=%0b tag=%h total=%0d",
							rsp.found, rsp.drawn_tag, rsp.remaining_total);
					end
					n_mismatch++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("no transfer for %0d cycles, %0d results outstanding", idle_cycles,
				pending_rsp.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		clear_table();
		build_stimulus();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (req_queue.size() != 0 || pending_rsp.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("requests: %0d (%0d clear, %0d load, %0d no-op, %0d draw hit, %0d draw empty)",
			n_accepted, n_clear, n_load, n_nop, n_hit, n_miss);
		$display("results checked: %0d, mismatches: %0d", n_results, n_mismatch);
		if (n_mismatch == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: weighted_draw_without_replacement_core.f
rtl/core/wdwr_pkg.sv
rtl/core/wdwr_table.sv
rtl/core/wdwr_pick.sv
rtl/core/weighted_draw_without_replacement_core.sv
rtl/core/wdwr_checker.sv
tb/sv/weighted_draw_without_replacement_core_tb.sv
